[rtl/mandelbrot_escape_iteration_unit_assert.svh]
// Assertion macros shared by the RTL files.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef MANDELBROT_ESCAPE_ITERATION_UNIT_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MEI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MEI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mei_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mei_pkg;

  localparam int FRAC_BITS_DEFAULT = 28;
  localparam int ITER_BITS_DEFAULT = 16;

  localparam int WORD_W = 64;
  localparam int COORD_W = 32;
  localparam int COUNT_W = 16;
  localparam int MAG_W = 32;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHECK_PERIOD = 2'd1;

  localparam logic [CFG_DATA_W-1:0] MAX_ITERATIONS_RESET = 16'd256;
  localparam logic [CFG_DATA_W-1:0] CHECK_PERIOD_RESET = 16'd20;

  localparam logic [1:0] OUT_ESCAPED = 2'd0;
  localparam logic [1:0] OUT_CARDIOID = 2'd1;
  localparam logic [1:0] OUT_LIMIT = 2'd2;
  localparam logic [1:0] OUT_PERIODIC = 2'd3;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [WORD_W-1:0] result;
  } mul_rsp_t;

  function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] s;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_add = s[WORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/mei_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mei_in_if
  import mei_pkg::*;
  ();
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] c_real;
  logic signed [COORD_W-1:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface mei_out_if
  import mei_pkg::*;
  ();
  logic valid;
  logic ready;
  logic [COUNT_W-1:0] iterations;
  logic [1:0] outcome;
  logic [MAG_W-1:0] magnitude_sq;

  modport source (output valid, output iterations, output outcome, output magnitude_sq,
                  input ready);
  modport sink (input valid, input iterations, input outcome, input magnitude_sq,
                output ready);
endinterface

`default_nettype wire

[rtl/mei_fx_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_iteration_unit_assert.svh"

module mei_fx_mul
  import mei_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_ABS  = 5'b00010,
    M_MAC  = 5'b00100,
    M_NEG  = 5'b01000,
    M_FIN  = 5'b10000
  } mul_state_t;

  mul_state_t state;
  logic signed [WORD_W-1:0] a_op;
  logic signed [WORD_W-1:0] b_op;
  logic [WORD_W-1:0] ua;
  logic [WORD_W-1:0] ub;
  logic neg;
  logic [1:0] step;
  logic [2*WORD_W-1:0] acc;
  logic signed [WORD_W-1:0] result;
  logic done;

  logic [31:0] a_half;
  logic [31:0] b_half;
  logic [63:0] pp;
  logic [1:0] half_sum;
  logic [2*WORD_W-1:0] pp_shifted;
  logic [WORD_W-1:0] trunc;
  logic [2*WORD_W-FRAC_BITS-WORD_W:0] top_bits;

  assign a_half = step[1] ? ua[63:32] : ua[31:0];
  assign b_half = step[0] ? ub[63:32] : ub[31:0];
  assign pp = {32'b0, a_half} * {32'b0, b_half};
  assign half_sum = {1'b0, step[1]} + {1'b0, step[0]};
  assign pp_shifted = {64'b0, pp} << {half_sum, 5'b0};
  assign trunc = acc[FRAC_BITS+WORD_W-1:FRAC_BITS];
  assign top_bits = acc[2*WORD_W-1:FRAC_BITS+WORD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (req.start) begin
            a_op <= req.a;
            b_op <= req.b;
            state <= M_ABS;
          end
        end
        M_ABS: begin
          neg <= a_op[WORD_W-1] ^ b_op[WORD_W-1];
          ua <= a_op[WORD_W-1] ? (~a_op + 64'd1) : a_op;
          ub <= b_op[WORD_W-1] ? (~b_op + 64'd1) : b_op;
          acc <= '0;
          step <= 2'd0;
          state <= M_MAC;
        end
        M_MAC: begin
          acc <= acc + pp_shifted;
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= M_NEG;
          end
        end
        M_NEG: begin
          if (neg) begin
            acc <= ~acc + 128'd1;
          end
          state <= M_FIN;
        end
        M_FIN: begin
          if (!((&top_bits) || !(|top_bits))) begin
            result <= acc[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
          end else begin
            result <= signed'(trunc);
          end
          done <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state != M_IDLE);
  assign rsp.done = done;
  assign rsp.result = result;

  `MEI_ASSERT_NOW(a_start_when_idle, req.start, !rsp.busy, "multiply started while busy")
  `MEI_ASSERT_NEXT(a_start_goes_busy, req.start, rsp.busy, "multiply start not taken")
  `MEI_ASSERT_NEXT(a_done_single, done, !done, "multiply done held over two cycles")

endmodule

`default_nettype wire

[rtl/mandelbrot_escape_iteration_unit.sv]
// Mandelbrot escape-time unit, one point at a time.
// in_ch carries a point c (c_real, c_imag, signed Q4.28); a transaction is taken
// when valid and ready are both high. ready is high only while the unit is idle.
// out_ch carries one result per point: iterations, outcome (0 escaped,
// 1 cardioid reject, 2 limit reached, 3 periodic cycle) and magnitude_sq.
// cfg_wr_en/cfg_index/cfg_data write max_iterations (index 0) and
// check_period (index 1); write only while no point is in flight.
// All arithmetic goes through one shared 64x64 fixed-point multiplier that
// forms four 32x32 partial products, one per cycle. The cardioid test and
// setup use five multiplies, each escape iteration three multiplies plus the
// check and update steps. ready returns in the same cycle that the result
// becomes valid.
// The result waits in an output register; if the receiver stalls, the unit
// still takes the next point and holds its finished result until the
// register frees. Synchronous reset returns to idle, drops any pending result
// and restores max_iterations = 256, check_period = 20.
`timescale 1ns / 1ps
`default_nettype none
`include "mandelbrot_escape_iteration_unit_assert.svh"

module mandelbrot_escape_iteration_unit
  import mei_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
  parameter int ITER_BITS = ITER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mei_in_if.sink                 in_ch,
  mei_out_if.source              out_ch
);

  typedef enum logic [11:0] {
    S_IDLE        = 12'b000000000001,
    S_CARD_Y2     = 12'b000000000010,
    S_CARD_XS2    = 12'b000000000100,
    S_CARD_LHS    = 12'b000000001000,
    S_CARD_RHS    = 12'b000000010000,
    S_INIT_ZRE    = 12'b000000100000,
    S_CHECK       = 12'b000001000000,
    S_LOOP_ZIM    = 12'b000010000000,
    S_LOOP_ZRE_SQ = 12'b000100000000,
    S_LOOP_ZIM_SQ = 12'b001000000000,
    S_UPDATE      = 12'b010000000000,
    S_DONE        = 12'b100000000000
  } state_t;

  localparam logic signed [WORD_W-1:0] QUARTER = 64'(1) << (FRAC_BITS - 2);
  localparam logic signed [WORD_W-1:0] FOUR = 64'(1) << (FRAC_BITS + 2);
  localparam logic [32:0] ITER_CAP = (33'd1 << ITER_BITS) - 33'd1;

  state_t state;
  state_t state_next;

  logic [CFG_DATA_W-1:0] max_iterations;
  logic [CFG_DATA_W-1:0] check_period;

  logic pending;
  logic is_card;
  logic [1:0] outcome;
  logic signed [WORD_W-1:0] cre;
  logic signed [WORD_W-1:0] cim;
  logic signed [WORD_W-1:0] xs;
  logic signed [WORD_W-1:0] y2;
  logic signed [WORD_W-1:0] q;
  logic signed [WORD_W-1:0] lhs;
  logic signed [WORD_W-1:0] zre;
  logic signed [WORD_W-1:0] zim;
  logic signed [WORD_W-1:0] zre_sq;
  logic signed [WORD_W-1:0] zim_sq;
  logic signed [WORD_W-1:0] diff;
  logic signed [WORD_W-1:0] l2;
  logic signed [WORD_W-1:0] ref_mag;
  logic [ITER_BITS-1:0] n;
  logic [CFG_DATA_W-1:0] pcnt;

  logic [ITER_BITS-1:0] limit;
  logic mul_state;
  logic out_free;
  logic in_fire;
  logic period_hit;
  logic signed [WORD_W-1:0] l2_new;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  mei_fx_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .req(mul_req),
    .rsp(mul_rsp)
  );

  assign limit = ITER_BITS'((33'(max_iterations) < ITER_CAP) ? 33'(max_iterations) : ITER_CAP);
  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign period_hit = (({1'b0, pcnt} + 17'd1) == {1'b0, check_period});
  assign l2_new = sat_add(zre_sq, mul_rsp.result);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITERATIONS_RESET;
      check_period <= CHECK_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_ITERATIONS: max_iterations <= cfg_data;
        REG_CHECK_PERIOD: check_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_state = 1'b1;
    mul_req.a = '0;
    mul_req.b = '0;
    unique case (state)
      S_CARD_Y2: begin
        mul_req.a = cim;
        mul_req.b = cim;
      end
      S_CARD_XS2: begin
        mul_req.a = xs;
        mul_req.b = xs;
      end
      S_CARD_LHS: begin
        mul_req.a = q;
        mul_req.b = sat_add(q, xs);
      end
      S_CARD_RHS: begin
        mul_req.a = QUARTER;
        mul_req.b = y2;
      end
      S_INIT_ZRE: begin
        mul_req.a = cre;
        mul_req.b = cre;
      end
      S_LOOP_ZIM: begin
        mul_req.a = sat_add(zre, zre);
        mul_req.b = zim;
      end
      S_LOOP_ZRE_SQ: begin
        mul_req.a = zre;
        mul_req.b = zre;
      end
      S_LOOP_ZIM_SQ: begin
        mul_req.a = zim;
        mul_req.b = zim;
      end
      default: mul_state = 1'b0;
    endcase
    mul_req.start = mul_state && !pending;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_CARD_Y2;
      S_CARD_Y2: if (mul_rsp.done) state_next = S_CARD_XS2;
      S_CARD_XS2: if (mul_rsp.done) state_next = S_CARD_LHS;
      S_CARD_LHS: if (mul_rsp.done) state_next = S_CARD_RHS;
      S_CARD_RHS: begin
        if (mul_rsp.done) begin
          state_next = (lhs <= mul_rsp.result) ? S_DONE : S_INIT_ZRE;
        end
      end
      S_INIT_ZRE: if (mul_rsp.done) state_next = S_CHECK;
      S_CHECK: state_next = (l2 < FOUR && n < limit) ? S_LOOP_ZIM : S_DONE;
      S_LOOP_ZIM: if (mul_rsp.done) state_next = S_LOOP_ZRE_SQ;
      S_LOOP_ZRE_SQ: if (mul_rsp.done) state_next = S_LOOP_ZIM_SQ;
      S_LOOP_ZIM_SQ: if (mul_rsp.done) state_next = S_UPDATE;
      S_UPDATE: state_next = (l2 == ref_mag) ? S_DONE : S_CHECK;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_req.start) begin
        pending <= 1'b1;
      end else if (mul_rsp.done) begin
        pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cre <= 64'(in_ch.c_real);
          cim <= 64'(in_ch.c_imag);
          xs <= 64'(in_ch.c_real) - QUARTER;
          zre <= 64'(in_ch.c_real);
          zim <= 64'(in_ch.c_imag);
          n <= '0;
          pcnt <= '0;
          is_card <= 1'b0;
        end
      end
      S_CARD_Y2: if (mul_rsp.done) y2 <= mul_rsp.result;
      S_CARD_XS2: if (mul_rsp.done) q <= sat_add(mul_rsp.result, y2);
      S_CARD_LHS: if (mul_rsp.done) lhs <= mul_rsp.result;
      S_CARD_RHS: begin
        if (mul_rsp.done && lhs <= mul_rsp.result) begin
          is_card <= 1'b1;
          outcome <= OUT_CARDIOID;
        end
      end
      S_INIT_ZRE: begin
        if (mul_rsp.done) begin
          zre_sq <= mul_rsp.result;
          zim_sq <= y2;
          l2 <= sat_add(mul_rsp.result, y2);
          ref_mag <= sat_add(mul_rsp.result, y2);
        end
      end
      S_CHECK: begin
        if (!(l2 < FOUR && n < limit)) begin
          outcome <= (n >= limit) ? OUT_LIMIT : OUT_ESCAPED;
        end
      end
      S_LOOP_ZIM: begin
        if (mul_req.start) begin
          diff <= sat_add(zre_sq, -zim_sq);
        end
        if (mul_rsp.done) begin
          zim <= sat_add(mul_rsp.result, cim);
          zre <= sat_add(diff, cre);
        end
      end
      S_LOOP_ZRE_SQ: if (mul_rsp.done) zre_sq <= mul_rsp.result;
      S_LOOP_ZIM_SQ: begin
        if (mul_rsp.done) begin
          zim_sq <= mul_rsp.result;
          l2 <= l2_new;
          n <= n + 1'b1;
        end
      end
      S_UPDATE: begin
        if (l2 == ref_mag) begin
          outcome <= OUT_PERIODIC;
        end else if (period_hit) begin
          ref_mag <= l2;
          pcnt <= '0;
        end else begin
          pcnt <= pcnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_ch.outcome <= outcome;
      if (is_card) begin
        out_ch.iterations <= '0;
        out_ch.magnitude_sq <= '0;
      end else begin
        out_ch.iterations <= COUNT_W'(n);
        if (l2[WORD_W-1]) begin
          out_ch.magnitude_sq <= '0;
        end else if (|l2[WORD_W-2:MAG_W]) begin
          out_ch.magnitude_sq <= '1;
        end else begin
          out_ch.magnitude_sq <= l2[MAG_W-1:0];
        end
      end
    end
  end

  `MEI_ASSERT_NOW(a_card_zero, out_ch.valid && out_ch.outcome == OUT_CARDIOID,
                  out_ch.iterations == '0 && out_ch.magnitude_sq == '0,
                  "cardioid reject with nonzero fields")
  `MEI_ASSERT_NOW(a_limit_count, out_ch.valid && out_ch.outcome == OUT_LIMIT,
                  out_ch.iterations == COUNT_W'(limit),
                  "limit outcome with count below limit")
  `MEI_ASSERT_NOW(a_count_bound, state != S_IDLE, n <= limit,
                  "iteration count past limit")

endmodule

`default_nettype wire

[tb/sv/mandelbrot_escape_iteration_unit_test.sv]
`timescale 1ns / 1ps

module mandelbrot_escape_iteration_unit_test;
  import mei_pkg::*;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iterations;
    logic [1:0]         outcome;
    logic [MAG_W-1:0]   magnitude_sq;
  } escape_result_t;

  localparam int FRAC = FRAC_BITS_DEFAULT;
  localparam word_t ONE_Q = 64'sd1 << FRAC;
  localparam word_t FOUR_Q = ONE_Q * 4;
  localparam word_t QUARTER_Q = ONE_Q / 4;
  localparam word_t MAG_CAP = 64'sh00000000FFFFFFFF;

  localparam coord_t COORD_MAX = 32'sh7FFFFFFF;
  localparam coord_t COORD_MIN = 32'sh80000000;
  localparam logic [31:0] SPAN3 = 32'd805306368;
  localparam logic [31:0] SPAN4 = 32'd1073741824;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned ITER_BUDGET = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 4000;
  localparam int unsigned WATCHDOG_CYCLES = 60000;
  localparam int unsigned SETTLE_CYCLES = 100;

  class escape_scoreboard;
    logic [CFG_DATA_W-1:0] iter_limit;
    logic [CFG_DATA_W-1:0] refresh_period;
    escape_result_t        expected_results[$];
    int unsigned           failures;

    function new();
      iter_limit = MAX_ITERATIONS_RESET;
      refresh_period = CHECK_PERIOD_RESET;
      failures = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_MAX_ITERATIONS) begin
        iter_limit = val;
      end else if (idx == REG_CHECK_PERIOD) begin
        refresh_period = val;
      end
    endfunction

    static function word_t q_mul(word_t a, word_t b);
      logic signed [2*WORD_W-1:0] wa;
      logic signed [2*WORD_W-1:0] wb;
      logic signed [2*WORD_W-1:0] prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> FRAC;
      if (prod[2*WORD_W-1:WORD_W-1] != {(WORD_W+1){prod[WORD_W-1]}}) begin
        return prod[2*WORD_W-1] ? WORD_MIN : WORD_MAX;
      end
      return prod[WORD_W-1:0];
    endfunction

    static function word_t q_add(word_t a, word_t b);
      logic signed [WORD_W:0] s;
      s = a;
      s = s + b;
      if (s > WORD_MAX) return WORD_MAX;
      if (s < WORD_MIN) return WORD_MIN;
      return s[WORD_W-1:0];
    endfunction

    function escape_result_t escape_time(coord_t re, coord_t im, int unsigned limit);
      word_t cre, cim, xs, y2, q, lhs, rhs;
      word_t zre, zim, zre2, zim2, mag, ref_mag;
      int unsigned n;
      bit cycle_hit;
      escape_result_t r;
      cre = re;
      cim = im;
      xs = cre - QUARTER_Q;
      y2 = q_mul(cim, cim);
      q = q_add(q_mul(xs, xs), y2);
      lhs = q_mul(q, q_add(q, xs));
      rhs = q_mul(QUARTER_Q, y2);
      if (lhs <= rhs) begin
        r.iterations = '0;
        r.outcome = OUT_CARDIOID;
        r.magnitude_sq = '0;
        return r;
      end
      zre = cre;
      zim = cim;
      zre2 = q_mul(zre, zre);
      zim2 = q_mul(zim, zim);
      mag = q_add(zre2, zim2);
      ref_mag = mag;
      n = 0;
      cycle_hit = 1'b0;
      while (mag < FOUR_Q && n < limit && !cycle_hit) begin
        zim = q_add(q_mul(q_add(zre, zre), zim), cim);
        zre = q_add(q_add(zre2, -zim2), cre);
        zre2 = q_mul(zre, zre);
        zim2 = q_mul(zim, zim);
        mag = q_add(zre2, zim2);
        n++;
        if (mag == ref_mag) begin
          cycle_hit = 1'b1;
        end else if (refresh_period != 0 && n % refresh_period == 0) begin
          ref_mag = mag;
        end
      end
      if (cycle_hit) begin
        r.outcome = OUT_PERIODIC;
      end else begin
        r.outcome = (n >= limit) ? OUT_LIMIT : OUT_ESCAPED;
      end
      r.iterations = n[COUNT_W-1:0];
      if (mag < 0) begin
        r.magnitude_sq = '0;
      end else if (mag > MAG_CAP) begin
        r.magnitude_sq = '1;
      end else begin
        r.magnitude_sq = mag[MAG_W-1:0];
      end
      return r;
    endfunction

    function void note_point(coord_t re, coord_t im);
      expected_results.push_back(escape_time(re, im, iter_limit));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      if (failures < 40) $display("[%0t] MISMATCH %s", $time, msg);
      failures++;
    endtask

    task check_result(logic [COUNT_W-1:0] it, logic [1:0] oc, logic [MAG_W-1:0] mag);
      escape_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result iterations=%0d outcome=%0d magnitude_sq=%h",
                         it, oc, mag));
        return;
      end
      want = expected_results.pop_front();
      if (it !== want.iterations)
        report($sformatf("iterations got %0d want %0d", it, want.iterations));
      if (oc !== want.outcome)
        report($sformatf("outcome got %0d want %0d", oc, want.outcome));
      if (mag !== want.magnitude_sq)
        report($sformatf("magnitude_sq got %h want %h", mag, want.magnitude_sq));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mei_in_if  in_ch ();
  mei_out_if out_ch ();

  mandelbrot_escape_iteration_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  escape_scoreboard sb = new();

  bit reset_done = 1'b0;
  bit hold_off_req = 1'b0;
  bit sink_idle_on = 1'b1;
  bit source_idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic coord_t to_q(real v);
    return $rtoi(v * 268435456.0);
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return -1;
      4: return to_q(1.0);
      5: return to_q(-1.0);
      6: return to_q(2.0);
      default: return to_q(-2.0);
    endcase
  endfunction

  task automatic pick_point(output coord_t re, output coord_t im);
    int unsigned mode;
    mode = $urandom_range(0, 99);
    if (mode < 20) begin
      re = $urandom;
      im = $urandom;
    end else if (mode < 70) begin
      re = to_q(-2.25) + $urandom_range(0, SPAN3);
      im = to_q(-1.5) + $urandom_range(0, SPAN3);
    end else if (mode < 88) begin
      re = to_q(-2.0) + $urandom_range(0, SPAN4);
      im = to_q(-2.0) + $urandom_range(0, SPAN4);
    end else begin
      re = edge_coord();
      im = edge_coord();
    end
  endtask

  task automatic send_point(input coord_t re, input coord_t im);
    int unsigned gap;
    gap = source_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.c_real <= re;
    in_ch.c_imag <= im;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(re, im);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] limit,
                           input logic [CFG_DATA_W-1:0] period);
    drain();
    write_reg(REG_MAX_ITERATIONS, limit);
    write_reg(REG_CHECK_PERIOD, period);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Skip points that would run far past the budget when the limit is large.
  task automatic run_phase(input int unsigned count, input bit pressure);
    coord_t re, im;
    escape_result_t probe;
    int unsigned k, tries;
    for (k = 0; k < count; k++) begin
      pick_point(re, im);
      if (sb.iter_limit > ITER_BUDGET) begin
        probe = sb.escape_time(re, im, ITER_BUDGET);
        tries = 0;
        while (probe.outcome == OUT_LIMIT && tries < 20) begin
          pick_point(re, im);
          probe = sb.escape_time(re, im, ITER_BUDGET);
          tries++;
        end
        if (probe.outcome == OUT_LIMIT) begin
          re = to_q(3.0);
          im = '0;
        end
      end
      if (pressure && k == count / 3) hold_off_req = 1'b1;
      if (pressure && k == (2 * count) / 3) drain();
      send_point(re, im);
    end
  endtask

  initial begin : sink_side
    int unsigned gap;
    out_ch.ready <= 1'b0;
    while (!reset_done) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = sink_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.iterations, out_ch.outcome, out_ch.magnitude_sq);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("mandelbrot_escape_iteration_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_MAX_ITERATIONS;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.c_real <= '0;
    in_ch.c_imag <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reset_done = 1'b1;

    // reset settings: cardioid, cusp, junction, cycles, escapes, saturation
    send_point('0, '0);
    send_point(to_q(-0.1), to_q(0.2));
    send_point(to_q(0.25), '0);
    send_point(to_q(-0.75), '0);
    send_point(to_q(-1.0), '0);
    send_point('0, to_q(1.0));
    send_point(to_q(1.0), '0);
    send_point(to_q(-2.0), '0);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MAX, COORD_MIN);
    send_point('0, COORD_MAX);
    send_point(COORD_MIN, '0);
    send_point(to_q(-0.75), to_q(0.1));
    send_point(to_q(0.26), '0);
    send_point(to_q(-1.5), '0);
    send_point(to_q(0.3), to_q(0.5));
    run_phase(60, 1'b0);

    configure(16'd0, 16'd1);
    send_point(to_q(1.0), '0);
    send_point('0, '0);
    send_point(to_q(-2.0), '0);
    run_phase(40, 1'b0);

    configure(16'd1, 16'd0);
    send_point(to_q(1.0), '0);
    run_phase(60, 1'b0);

    configure(16'd2, 16'd65535);
    send_point(to_q(-1.0), '0);
    run_phase(60, 1'b0);

    configure(16'd65535, 16'd65535);
    send_point(to_q(-1.0), '0);
    send_point('0, to_q(1.0));
    send_point(COORD_MIN, COORD_MAX);
    run_phase(80, 1'b0);

    configure(16'd37, 16'd7);
    run_phase(150, 1'b1);

    configure(16'd64, 16'd0);
    sink_idle_on = 1'b0;
    source_idle_on = 1'b0;
    run_phase(120, 1'b0);
    sink_idle_on = 1'b1;
    source_idle_on = 1'b1;

    configure(16'd65535, 16'd1);
    run_phase(60, 1'b0);

    for (p = 0; p < 3; p++) begin
      configure(CFG_DATA_W'($urandom_range(1, 80)), CFG_DATA_W'($urandom_range(0, 40)));
      run_phase(90, 1'b0);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("mandelbrot_escape_iteration_unit verification clean");
    end else begin
      $display("mandelbrot_escape_iteration_unit verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/mei_pkg.sv
rtl/mei_if.sv
rtl/mei_fx_mul.sv
rtl/mandelbrot_escape_iteration_unit.sv
tb/sv/mandelbrot_escape_iteration_unit_test.sv
